// ===== rtl/segment_intersection_core_defines.svh =====
// ----------------------------------------------------------------------------
// segment_intersection_core_defines
// Assertion macros for the checker file of the intersection core.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SEGI_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("segment intersection check failed");

// next-cycle implication, sampled on clk, off during rst
`define SEGI_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("segment intersection check failed");

`endif

// ===== rtl/segi_pkg.sv =====
// ----------------------------------------------------------------------------
// segi_pkg
// Widths, result codes and divider interface types of the intersection core.
// ----------------------------------------------------------------------------
package segi_pkg;

  localparam int CW  = 24;            // coordinate width
  localparam int DW  = CW + 1;        // coordinate difference
  localparam int PW  = 2 * DW;        // difference product
  localparam int NW  = PW + 1;        // denominator and numerators
  localparam int SPL = (NW + 1) / 2;  // low slice of a split multiplier operand
  localparam int HW  = NW - SPL;      // high slice
  localparam int LPW = DW + SPL + 1;  // low partial product
  localparam int HPW = DW + HW;       // high partial product
  localparam int XW  = HPW + SPL;     // scaled point numerator
  localparam int MW  = XW - 1;        // numerator magnitude
  localparam int QW  = CW + 1;        // quotient bits kept before saturation

  localparam int IN_DW  = 8 * CW;
  localparam int OUT_DW = 2 * CW;
  localparam int OUT_UW = 3;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_UNBOUND = 2'd1;
  localparam logic [1:0] KIND_BOUNDED = 2'd2;

  localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [NW-1:0] den;
    logic [MW-1:0] mag_x;
    logic [MW-1:0] mag_y;
    logic          neg_x;
    logic          neg_y;
    logic          bounded;
    logic          dz;
  } div_in_t;

  typedef struct packed {
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic          ovf_x;
    logic          ovf_y;
    logic          neg_x;
    logic          neg_y;
    logic          bounded;
    logic          dz;
  } div_out_t;

endpackage

// ===== rtl/segment_intersection_core.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_core
// Exact fixed-point intersection of two 2D segments, streaming in and out.
// ----------------------------------------------------------------------------
// One segment pair is accepted per clock while s_tready is high, and one
// result leaves per pair, in order. A pair passes through stages of
// differences, cross products, sign fixup, split multiplies and sums, then
// 26 divider stages (an overflow check and one quotient bit per stage,
// shared by x and y), then the output buffer. The whole pipeline
// advances together; a two-entry output buffer lets one result wait while
// new pairs are still taken, and s_tready drops only when both entries are
// full. Parallel or degenerate segments give kind none with a zero point.
module segment_intersection_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // p0_x, p0_y, p1_x, p1_y, q0_x, q0_y, q1_x, q1_y (24 bits each)
  input  logic [segi_pkg::IN_DW-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // hit_x, hit_y (24 bits each)
  output logic [segi_pkg::OUT_DW-1:0] m_tdata,
  // hit_kind (2 bits), clipped (1 bit)
  output logic [segi_pkg::OUT_UW-1:0] m_tuser
);
  import segi_pkg::*;

  logic en;

  logic signed [CW-1:0] i_p0x, i_p0y, i_p1x, i_p1y, i_q0x, i_q0y, i_q1x, i_q1y;
  assign i_p0x = $signed(s_tdata[1*CW-1:0*CW]);
  assign i_p0y = $signed(s_tdata[2*CW-1:1*CW]);
  assign i_p1x = $signed(s_tdata[3*CW-1:2*CW]);
  assign i_p1y = $signed(s_tdata[4*CW-1:3*CW]);
  assign i_q0x = $signed(s_tdata[5*CW-1:4*CW]);
  assign i_q0y = $signed(s_tdata[6*CW-1:5*CW]);
  assign i_q1x = $signed(s_tdata[7*CW-1:6*CW]);
  assign i_q1y = $signed(s_tdata[8*CW-1:7*CW]);

  logic [8:1] v;

  // stage 1: differences
  logic signed [DW-1:0] a_ax, a_ay, a_bx, a_by, a_cx, a_cy;
  logic signed [CW-1:0] a_p0x, a_p0y;
  // stage 2: cross products
  logic signed [PW-1:0] b_m1, b_m2, b_m3, b_m4, b_m5, b_m6;
  logic signed [DW-1:0] b_ax, b_ay;
  logic signed [CW-1:0] b_p0x, b_p0y;
  // stage 3: denominator and numerators
  logic signed [NW-1:0] c_den, c_na, c_nb;
  logic signed [DW-1:0] c_ax, c_ay;
  logic signed [CW-1:0] c_p0x, c_p0y;
  // stage 4: positive denominator
  logic signed [NW-1:0] d_den, d_na, d_nb;
  logic signed [DW-1:0] d_ax, d_ay;
  logic signed [CW-1:0] d_p0x, d_p0y;
  logic                 d_dz;
  // stage 5: partial products
  logic signed [LPW-1:0] e_pxl, e_pyl, e_axl, e_ayl;
  logic signed [HPW-1:0] e_pxh, e_pyh, e_axh, e_ayh;
  logic [NW-1:0]         e_den;
  logic                  e_dz, e_inside;
  // stage 6: full products
  logic signed [XW-1:0]  f_px, f_py, f_ax, f_ay;
  logic [NW-1:0]         f_den;
  logic                  f_dz, f_inside;
  // stage 7: point numerators
  logic signed [XW-1:0]  g_nx, g_ny;
  logic [NW-1:0]         g_den;
  logic                  g_dz, g_inside;
  // stage 8: divider operands
  div_in_t               h_div;

  logic signed [SPL:0]   dlo_s, nlo_s;
  logic signed [HW-1:0]  dhi_s, nhi_s;
  logic signed [NW:0]    dna, dnb;

  always_comb begin
    dlo_s = $signed({1'b0, d_den[SPL-1:0]});
    dhi_s = $signed(d_den[NW-1:SPL]);
    nlo_s = $signed({1'b0, d_na[SPL-1:0]});
    nhi_s = $signed(d_na[NW-1:SPL]);
    dna   = (NW+1)'(d_den) - (NW+1)'(d_na);
    dnb   = (NW+1)'(d_den) - (NW+1)'(d_nb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], s_tvalid};
    end
    if (en) begin
      a_ax  <= DW'(i_p1x) - DW'(i_p0x);
      a_ay  <= DW'(i_p1y) - DW'(i_p0y);
      a_bx  <= DW'(i_q0x) - DW'(i_q1x);
      a_by  <= DW'(i_q0y) - DW'(i_q1y);
      a_cx  <= DW'(i_p0x) - DW'(i_q0x);
      a_cy  <= DW'(i_p0y) - DW'(i_q0y);
      a_p0x <= i_p0x;
      a_p0y <= i_p0y;

      b_m1  <= a_ay * a_bx;
      b_m2  <= a_ax * a_by;
      b_m3  <= a_by * a_cx;
      b_m4  <= a_bx * a_cy;
      b_m5  <= a_ax * a_cy;
      b_m6  <= a_ay * a_cx;
      b_ax  <= a_ax;
      b_ay  <= a_ay;
      b_p0x <= a_p0x;
      b_p0y <= a_p0y;

      c_den <= NW'(b_m1) - NW'(b_m2);
      c_na  <= NW'(b_m3) - NW'(b_m4);
      c_nb  <= NW'(b_m5) - NW'(b_m6);
      c_ax  <= b_ax;
      c_ay  <= b_ay;
      c_p0x <= b_p0x;
      c_p0y <= b_p0y;

      if (c_den[NW-1]) begin
        d_den <= -c_den;
        d_na  <= -c_na;
        d_nb  <= -c_nb;
      end else begin
        d_den <= c_den;
        d_na  <= c_na;
        d_nb  <= c_nb;
      end
      d_dz  <= (c_den == '0);
      d_ax  <= c_ax;
      d_ay  <= c_ay;
      d_p0x <= c_p0x;
      d_p0y <= c_p0y;

      e_pxl    <= d_p0x * dlo_s;
      e_pxh    <= d_p0x * dhi_s;
      e_pyl    <= d_p0y * dlo_s;
      e_pyh    <= d_p0y * dhi_s;
      e_axl    <= d_ax * nlo_s;
      e_axh    <= d_ax * nhi_s;
      e_ayl    <= d_ay * nlo_s;
      e_ayh    <= d_ay * nhi_s;
      e_den    <= d_den;
      e_dz     <= d_dz;
      e_inside <= !d_na[NW-1] && !dna[NW] && !d_nb[NW-1] && !dnb[NW];

      f_px     <= $signed({e_pxh, SPL'(0)}) + XW'(e_pxl);
      f_py     <= $signed({e_pyh, SPL'(0)}) + XW'(e_pyl);
      f_ax     <= $signed({e_axh, SPL'(0)}) + XW'(e_axl);
      f_ay     <= $signed({e_ayh, SPL'(0)}) + XW'(e_ayl);
      f_den    <= e_den;
      f_dz     <= e_dz;
      f_inside <= e_inside;

      g_nx     <= f_px + f_ax;
      g_ny     <= f_py + f_ay;
      g_den    <= f_den;
      g_dz     <= f_dz;
      g_inside <= f_inside;

      h_div.den     <= g_den;
      h_div.neg_x   <= g_nx[XW-1];
      h_div.neg_y   <= g_ny[XW-1];
      h_div.mag_x   <= g_nx[XW-1] ? MW'(-g_nx) : MW'(g_nx);
      h_div.mag_y   <= g_ny[XW-1] ? MW'(-g_ny) : MW'(g_ny);
      h_div.bounded <= g_inside;
      h_div.dz      <= g_dz;
    end
  end

  logic     dv;
  div_out_t dq;

  segi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v[8]),
    .din       (h_div),
    .out_valid (dv),
    .dout      (dq)
  );

  // saturate and format
  logic [CW-1:0]     hx, hy;
  logic              sx, sy;
  logic [OUT_DW+OUT_UW-1:0] res;

  always_comb begin
    if (dq.neg_x) begin
      sx = dq.ovf_x || (dq.q_x > QW'(COORD_MIN));
      hx = sx ? COORD_MIN : CW'(QW'(0) - dq.q_x);
    end else begin
      sx = dq.ovf_x || (dq.q_x > QW'(COORD_MAX));
      hx = sx ? COORD_MAX : dq.q_x[CW-1:0];
    end
    if (dq.neg_y) begin
      sy = dq.ovf_y || (dq.q_y > QW'(COORD_MIN));
      hy = sy ? COORD_MIN : CW'(QW'(0) - dq.q_y);
    end else begin
      sy = dq.ovf_y || (dq.q_y > QW'(COORD_MAX));
      hy = sy ? COORD_MAX : dq.q_y[CW-1:0];
    end
    if (dq.dz) begin
      res = '0;
    end else begin
      res = {sx || sy, dq.bounded ? KIND_BOUNDED : KIND_UNBOUND, hy, hx};
    end
  end

  // two-entry output buffer
  logic [1:0]                cnt;
  logic [OUT_DW+OUT_UW-1:0]  ent0, ent1;
  logic                      push, pop;

  assign en       = (cnt != 2'd2);
  assign s_tready = en;
  assign push     = en && dv;
  assign m_tvalid = (cnt != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = ent0[OUT_DW-1:0];
  assign m_tuser  = ent0[OUT_DW+OUT_UW-1:OUT_DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (pop) begin
      if (cnt == 2'd2) begin
        ent0 <= ent1;
      end else if (push) begin
        ent0 <= res;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        ent0 <= res;
      end else begin
        ent1 <= res;
      end
    end
  end

endmodule

// ===== rtl/segi_div.sv =====
// ----------------------------------------------------------------------------
// segi_div
// Pipelined restoring divider for both point coordinates, one quotient bit
// per stage, with an overflow check ahead of the first bit.
// ----------------------------------------------------------------------------
module segi_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  segi_pkg::div_in_t  din,
  output logic               out_valid,
  output segi_pkg::div_out_t dout
);
  import segi_pkg::*;

  typedef struct packed {
    logic [NW-1:0] den;
    logic [MW-1:0] r_x;
    logic [MW-1:0] r_y;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic          ovf_x;
    logic          ovf_y;
    logic          neg_x;
    logic          neg_y;
    logic          bounded;
    logic          dz;
  } work_t;

  work_t         st [0:QW];
  logic [QW:0]   v;
  logic [MW:0]   top_sh;

  // quotient of 2**QW or more always saturates
  assign top_sh = (MW+1)'(din.den) << QW;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      st[0].den     <= din.den;
      st[0].r_x     <= din.mag_x;
      st[0].r_y     <= din.mag_y;
      st[0].q_x     <= '0;
      st[0].q_y     <= '0;
      st[0].ovf_x   <= {1'b0, din.mag_x} >= top_sh;
      st[0].ovf_y   <= {1'b0, din.mag_y} >= top_sh;
      st[0].neg_x   <= din.neg_x;
      st[0].neg_y   <= din.neg_y;
      st[0].bounded <= din.bounded;
      st[0].dz      <= din.dz;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int S = QW - j;
    logic [MW:0] sh;
    logic        ge_x;
    logic        ge_y;
    work_t       nxt;

    always_comb begin
      sh   = (MW+1)'(st[j-1].den) << S;
      ge_x = {1'b0, st[j-1].r_x} >= sh;
      ge_y = {1'b0, st[j-1].r_y} >= sh;
      nxt  = st[j-1];
      if (ge_x) begin
        nxt.r_x    = st[j-1].r_x - sh[MW-1:0];
        nxt.q_x[S] = 1'b1;
      end
      if (ge_y) begin
        nxt.r_y    = st[j-1].r_y - sh[MW-1:0];
        nxt.q_y[S] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v[j-1];
      end
      if (en) begin
        st[j] <= nxt;
      end
    end
  end

  assign out_valid    = v[QW];
  assign dout.q_x     = st[QW].q_x;
  assign dout.q_y     = st[QW].q_y;
  assign dout.ovf_x   = st[QW].ovf_x;
  assign dout.ovf_y   = st[QW].ovf_y;
  assign dout.neg_x   = st[QW].neg_x;
  assign dout.neg_y   = st[QW].neg_y;
  assign dout.bounded = st[QW].bounded;
  assign dout.dz      = st[QW].dz;

endmodule

// ===== rtl/segi_check.sv =====
// ----------------------------------------------------------------------------
// segi_check
// Port-level checks of the intersection core, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_intersection_core_defines.svh"

module segi_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [segi_pkg::OUT_DW-1:0] m_tdata,
  input logic [segi_pkg::OUT_UW-1:0] m_tuser
);
  import segi_pkg::*;

  logic [CW-1:0] cx, cy;
  assign cx = m_tdata[CW-1:0];
  assign cy = m_tdata[2*CW-1:CW];

  `SEGI_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `SEGI_ASSERT_NOW(a_none_zero, m_tvalid && (m_tuser[1:0] == KIND_NONE), (m_tdata == '0) && !m_tuser[2])
  `SEGI_ASSERT_NOW(a_kind_code, m_tvalid, m_tuser[1:0] != 2'b11)
  `SEGI_ASSERT_NOW(a_clip_limit, m_tvalid && m_tuser[2], (cx == COORD_MAX) || (cx == COORD_MIN) || (cy == COORD_MAX) || (cy == COORD_MIN))

endmodule

bind segment_intersection_core segi_check u_segi_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
